@@ rtl/tcp_pkg.sv @@
package tcp_pkg;

  // Coordinate and intermediate widths
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned SQ_W      = 2 * DIFF_W;
  localparam int unsigned SUMSQ_W   = SQ_W + 1;
  localparam int unsigned ROOT_W    = (SUMSQ_W + 1) / 2;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned PROD_W    = COORD_W + DIFF_W;
  localparam int unsigned AREA_W    = PROD_W + 2;
  localparam int unsigned PERIM_W   = 20;

  // Pipeline depths: difference, square, sum, then one stage per root bit
  localparam int unsigned PRE_STAGES = 3;
  localparam int unsigned LANE_LAT   = PRE_STAGES + ROOT_W;
  // Area lane registers differences, then products, before the flag delay
  localparam int unsigned AREA_STAGES = 2;
  localparam int unsigned FLAG_DLY   = LANE_LAT - AREA_STAGES;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tcp_in_t;

  typedef struct packed {
    logic               is_triangle;
    logic [PERIM_W-1:0] perimeter;
  } tcp_out_t;

endpackage

@@ rtl/triangle_check_and_perimeter.sv @@
// Triangle test and perimeter of three fixed-point points.
// A result strobes on done_o after start is taken, passing through
// 3 square-sum stages, 18 square-root stages and 1 merge stage.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Reset clears only the valid pipeline; data registers are not reset.
module triangle_check_and_perimeter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tcp_pkg::tcp_in_t  in_i,
  output logic              done_o,
  output tcp_pkg::tcp_out_t result_o
);
  import tcp_pkg::*;

  logic [LANE_LAT-1:0] valid_q;
  logic                accept;
  logic                tri_flag;
  logic [ROOT_W-1:0]   len_ab, len_bc, len_ac;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Track transactions through the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LANE_LAT-2:0], accept};
    end
  end

  // Side length lanes
  tcp_side_lane u_side_ab (
    .clk_i (clk_i),
    .x0_i  (in_i.ax),
    .y0_i  (in_i.ay),
    .x1_i  (in_i.bx),
    .y1_i  (in_i.by),
    .len_o (len_ab)
  );

  tcp_side_lane u_side_bc (
    .clk_i (clk_i),
    .x0_i  (in_i.bx),
    .y0_i  (in_i.by),
    .x1_i  (in_i.cx),
    .y1_i  (in_i.cy),
    .len_o (len_bc)
  );

  tcp_side_lane u_side_ac (
    .clk_i (clk_i),
    .x0_i  (in_i.ax),
    .y0_i  (in_i.ay),
    .x1_i  (in_i.cx),
    .y1_i  (in_i.cy),
    .len_o (len_ac)
  );

  // Doubled area lane
  tcp_area_lane u_area (
    .clk_i (clk_i),
    .pts_i (in_i),
    .tri_o (tri_flag)
  );

  // Combine lane results
  tcp_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_q[LANE_LAT-1]),
    .tri_i    (tri_flag),
    .len_ab_i (len_ab),
    .len_bc_i (len_bc),
    .len_ac_i (len_ac),
    .valid_o  (done_o),
    .result_o (result_o)
  );

endmodule

@@ rtl/tcp_isqrt.sv @@
module tcp_isqrt (
  input  logic                        clk_i,
  input  logic [tcp_pkg::RAD_W-1:0]   rad_i,
  output logic [tcp_pkg::ROOT_W-1:0]  root_o
);
  import tcp_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // One root bit per stage, restoring digit recurrence
  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_in << 2;
      rem_q[s]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[s] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

@@ rtl/tcp_side_lane.sv @@
module tcp_side_lane (
  input  logic                                clk_i,
  input  logic signed [tcp_pkg::COORD_W-1:0]  x0_i,
  input  logic signed [tcp_pkg::COORD_W-1:0]  y0_i,
  input  logic signed [tcp_pkg::COORD_W-1:0]  x1_i,
  input  logic signed [tcp_pkg::COORD_W-1:0]  y1_i,
  output logic [tcp_pkg::ROOT_W-1:0]          len_o
);
  import tcp_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        mag_x_q, mag_y_q;
  logic [SQ_W-1:0]          sq_x_q, sq_y_q;
  logic [SUMSQ_W-1:0]       sum_q;

  assign dx = DIFF_W'(x1_i) - DIFF_W'(x0_i);
  assign dy = DIFF_W'(y1_i) - DIFF_W'(y0_i);

  // Magnitudes, squares, then the squared length
  always_ff @(posedge clk_i) begin
    mag_x_q <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    mag_y_q <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sq_x_q  <= SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
    sq_y_q  <= SQ_W'(mag_y_q) * SQ_W'(mag_y_q);
    sum_q   <= SUMSQ_W'(sq_x_q) + SUMSQ_W'(sq_y_q);
  end

  tcp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (RAD_W'(sum_q)),
    .root_o (len_o)
  );

endmodule

@@ rtl/tcp_area_lane.sv @@
module tcp_area_lane (
  input  logic            clk_i,
  input  tcp_pkg::tcp_in_t pts_i,
  output logic            tri_o
);
  import tcp_pkg::*;

  logic signed [DIFF_W-1:0]  d1_q, d2_q, d3_q;
  logic signed [COORD_W-1:0] x1_q, x2_q, x3_q;
  logic signed [PROD_W-1:0]  p1_q, p2_q, p3_q;
  logic signed [AREA_W-1:0]  area;
  logic [FLAG_DLY-1:0]       nz_q;

  // Differences, products, then the doubled area test
  always_ff @(posedge clk_i) begin
    d1_q <= DIFF_W'(pts_i.by) - DIFF_W'(pts_i.cy);
    d2_q <= DIFF_W'(pts_i.cy) - DIFF_W'(pts_i.ay);
    d3_q <= DIFF_W'(pts_i.ay) - DIFF_W'(pts_i.by);
    x1_q <= pts_i.ax;
    x2_q <= pts_i.bx;
    x3_q <= pts_i.cx;
    p1_q <= PROD_W'(x1_q) * PROD_W'(d1_q);
    p2_q <= PROD_W'(x2_q) * PROD_W'(d2_q);
    p3_q <= PROD_W'(x3_q) * PROD_W'(d3_q);
  end

  assign area = AREA_W'(p1_q) + AREA_W'(p2_q) + AREA_W'(p3_q);

  // Align the flag with the side lanes
  always_ff @(posedge clk_i) begin
    nz_q <= {nz_q[FLAG_DLY-2:0], (area != '0)};
  end

  assign tri_o = nz_q[FLAG_DLY-1];

endmodule

@@ rtl/tcp_merge.sv @@
module tcp_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        tri_i,
  input  logic [tcp_pkg::ROOT_W-1:0]  len_ab_i,
  input  logic [tcp_pkg::ROOT_W-1:0]  len_bc_i,
  input  logic [tcp_pkg::ROOT_W-1:0]  len_ac_i,
  output logic                        valid_o,
  output tcp_pkg::tcp_out_t           result_o
);
  import tcp_pkg::*;

  logic               valid_q;
  tcp_out_t           res_d, res_q;
  logic [PERIM_W-1:0] sum;

  // Add the three sides, drop the sum when collinear
  assign sum = PERIM_W'(len_ab_i) + PERIM_W'(len_bc_i) + PERIM_W'(len_ac_i);

  always_comb begin
    res_d.is_triangle = tri_i;
    res_d.perimeter   = tri_i ? sum : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

@@ tb/tcp_checker.sv @@
// Watches both sides of the triangle/perimeter block, predicts each result
// from the accepted points and compares it against what comes out.
module tcp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  tcp_pkg::tcp_in_t  points_i,
  input  logic              done_i,
  input  tcp_pkg::tcp_out_t result_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       n_pending_o
);

  import tcp_pkg::*;

  tcp_out_t    perim_q[$];
  tcp_out_t    want;
  int unsigned fails;

  // Floor of the square root, built one result bit at a time from the top.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= n) r = cand;
    end
    return r;
  endfunction

  // Floored distance between two points in raw fixed-point units.
  function automatic longint unsigned seg_len(longint x0, longint y0,
                                              longint x1, longint y1);
    longint dx;
    longint dy;
    dx = x1 - x0;
    dy = y1 - y0;
    return floor_root(longint'(dx * dx + dy * dy));
  endfunction

  // Expected flag and perimeter for one set of three points.
  function automatic tcp_out_t predict_perimeter(tcp_in_t p);
    longint          x1, y1, x2, y2, x3, y3;
    longint          area2;
    longint unsigned sum;
    tcp_out_t        r;
    x1 = longint'($signed(p.ax));
    y1 = longint'($signed(p.ay));
    x2 = longint'($signed(p.bx));
    y2 = longint'($signed(p.by));
    x3 = longint'($signed(p.cx));
    y3 = longint'($signed(p.cy));
    area2 = x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2);
    r = '0;
    if (area2 != 0) begin
      sum = seg_len(x1, y1, x2, y2) + seg_len(x2, y2, x3, y3)
          + seg_len(x1, y1, x3, y3);
      r.is_triangle = 1'b1;
      r.perimeter   = sum[PERIM_W-1:0];
    end
    return r;
  endfunction

  // Retire results against the oldest prediction, then log new transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perim_q.delete();
      fails = 0;
      fail_cnt_o  <= 0;
      n_pending_o <= 0;
    end else begin
      if (done_i) begin
        if (perim_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got flag %0b perimeter %0d",
                   $time, result_i.is_triangle, result_i.perimeter);
          fails++;
        end else begin
          want = perim_q.pop_front();
          if (result_i.is_triangle !== want.is_triangle) begin
            $display("%0t: is_triangle mismatch, expected %0b, got %0b",
                     $time, want.is_triangle, result_i.is_triangle);
            fails++;
          end
          if (result_i.perimeter !== want.perimeter) begin
            $display("%0t: perimeter mismatch, expected %0d, got %0d",
                     $time, want.perimeter, result_i.perimeter);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) perim_q.push_back(predict_perimeter(points_i));
      fail_cnt_o  <= fails;
      n_pending_o <= perim_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Drives point triples into the triangle/perimeter block and gives the verdict.
module tb_top;

  import tcp_pkg::*;

  localparam int unsigned N_RANDOM    = 500;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  tcp_in_t     points;
  logic        done;
  tcp_out_t    result;
  int unsigned fail_cnt;
  int unsigned n_pending;
  int unsigned quiet_cycles;

  triangle_check_and_perimeter u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_i     (points),
    .done_o   (done),
    .result_o (result)
  );

  tcp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .points_i    (points),
    .done_i      (done),
    .result_i    (result),
    .fail_cnt_o  (fail_cnt),
    .n_pending_o (n_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort when nothing moves on either side for too long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic tcp_in_t mk_pts(int ax, int ay, int bx, int by, int cx, int cy);
    tcp_in_t p;
    p.ax = ax[COORD_W-1:0];
    p.ay = ay[COORD_W-1:0];
    p.bx = bx[COORD_W-1:0];
    p.by = by[COORD_W-1:0];
    p.cx = cx[COORD_W-1:0];
    p.cy = cy[COORD_W-1:0];
    return p;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(1023)) - 512;
  endfunction

  // Pick one random triple, biased toward collinear and corner cases.
  function automatic tcp_in_t rand_pts();
    tcp_in_t p;
    int      sel;
    int      x0, y0, dx, dy, k1, k2;
    sel = $urandom_range(99);
    p = tcp_in_t'({$urandom, $urandom, $urandom});
    if (sel >= 40 && sel < 55) begin
      x0 = int'($urandom_range(32000)) - 16000;
      y0 = int'($urandom_range(32000)) - 16000;
      dx = int'($urandom_range(4000)) - 2000;
      dy = int'($urandom_range(4000)) - 2000;
      k1 = int'($urandom_range(16)) - 8;
      k2 = int'($urandom_range(16)) - 8;
      p = mk_pts(x0, y0, x0 + k1 * dx, y0 + k1 * dy, x0 + k2 * dx, y0 + k2 * dy);
    end else if (sel >= 55 && sel < 65) begin
      case ($urandom_range(2))
        0:       begin p.bx = p.ax; p.by = p.ay; end
        1:       begin p.cx = p.bx; p.cy = p.by; end
        default: begin p.cx = p.ax; p.cy = p.ay; end
      endcase
    end else if (sel >= 65 && sel < 80) begin
      p = mk_pts(edge_coord(), edge_coord(), edge_coord(),
                 edge_coord(), edge_coord(), edge_coord());
    end else if (sel >= 80) begin
      p = mk_pts(near_coord(), near_coord(), near_coord(),
                 near_coord(), near_coord(), near_coord());
    end
    return p;
  endfunction

  // Present one transaction, with optional random idle cycles ahead of it.
  task automatic send_pts(tcp_in_t p, bit allow_idle);
    if (allow_idle) begin
      while ($urandom_range(99) < 22) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    points <= p;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
  endtask

  initial begin
    tcp_in_t drc[$];

    rst_ni = 1'b0;
    start  = 1'b0;
    points = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: coincident, collinear, extreme and tiny triangles.
    drc.push_back(mk_pts(0, 0, 0, 0, 0, 0));
    drc.push_back(mk_pts(-32768, -32768, -32768, -32768, -32768, -32768));
    drc.push_back(mk_pts(32767, 32767, 32767, 32767, 32767, 32767));
    drc.push_back(mk_pts(-32768, -32768, 32767, -32768, -32768, 32767));
    drc.push_back(mk_pts(32767, 32767, -32768, 32767, 32767, -32768));
    drc.push_back(mk_pts(-32768, -32768, 0, 0, 32767, 32767));
    drc.push_back(mk_pts(100, -200, 100, -200, 3000, 4000));
    drc.push_back(mk_pts(-5000, 7, 32767, -32768, -5000, 7));
    drc.push_back(mk_pts(-32768, 32767, 1234, -4321, 1234, -4321));
    drc.push_back(mk_pts(1, 5, 100, 5, -7, 5));
    drc.push_back(mk_pts(-9, 32767, -9, -32768, -9, 0));
    drc.push_back(mk_pts(0, 0, 1, 0, 0, 1));
    drc.push_back(mk_pts(0, 0, 768, 0, 0, 1024));
    drc.push_back(mk_pts(0, 0, 2, 1, 4, 3));
    drc.push_back(mk_pts(32767, -32768, -32768, 32767, 0, -1));
    drc.push_back(mk_pts(-1, -1, 0, 0, -1, 0));
    drc.push_back(mk_pts(-32768, 0, 32767, 0, 0, 32767));
    drc.push_back(mk_pts(0, -32768, 0, 32767, -32768, 0));
    drc.push_back(mk_pts(32767, 32766, 0, 0, -32767, -32766));
    foreach (drc[i]) send_pts(drc[i], 1'b1);

    // Random triples; one stretch runs back to back, two pauses drain fully.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150 || n == 400) wait_drained();
      send_pts(rand_pts(), !(n >= 200 && n < 300));
    end
    start <= 1'b0;

    // Drain, then keep waiting for any stray result before the verdict.
    do @(posedge clk_i); while (n_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
